>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock outside reset
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/ips_pkg.sv
package ips_pkg;

  localparam int PIX_W        = 24;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;
  localparam int FACTOR_REG_W = 4;
  localparam int DIM_REG_W    = 13;
  localparam int MAX_ROWS     = 4096;
  localparam int ROW_IDX_W    = 12;
  localparam int ROW_W        = 13;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_FACTOR = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_COUNT  = 2'd3
  } ips_reg_e;

  localparam logic MODE_UP     = 1'b0;
  localparam logic MODE_DOWN   = 1'b1;
  localparam logic REQ_PIXEL   = 1'b0;
  localparam logic REQ_REPLAY  = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
  } ips_job_t;

endpackage

>>> rtl/ips_req_if.sv
interface ips_req_if import ips_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, req_type, pixel_in, input ready);
  modport sink (input valid, req_type, pixel_in, output ready);
endinterface

>>> rtl/ips_res_if.sv
interface ips_res_if import ips_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             row_end;
  logic             last;

  modport source (output valid, pixel_out, row_end, last, input ready);
  modport sink (input valid, pixel_out, row_end, last, output ready);
endinterface

>>> rtl/ips_emit.sv
module ips_emit import ips_pkg::*; #(
  parameter int FW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  ips_job_t        job_i,
  input  logic [FW-1:0]   copies_i,
  output logic            job_take_o,
  ips_res_if.source       res_o
);

  logic             busy_q;
  ips_job_t         job_q;
  logic [FW-1:0]    left_q;
  logic             out_valid_q;
  logic [PIX_W-1:0] out_pix_q;
  logic             out_end_q;
  logic             out_last_q;

  logic out_free;
  logic emit;
  logic finishing;

  assign out_free   = !out_valid_q || res_o.ready;
  assign emit       = busy_q && out_free;
  assign finishing  = emit && (left_q == FW'(1));
  assign job_take_o = job_valid_i && (!busy_q || finishing);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_take_o) begin
        busy_q <= 1'b1;
      end else if (finishing) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      job_q  <= job_i;
      left_q <= copies_i;
    end else if (emit) begin
      left_q <= left_q - FW'(1);
    end
    if (emit) begin
      out_pix_q  <= job_q.pixel;
      out_last_q <= (left_q == FW'(1));
      out_end_q  <= (left_q == FW'(1)) && job_q.row_end;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.pixel_out = out_pix_q;
  assign res_o.row_end   = out_end_q;
  assign res_o.last      = out_last_q;

endmodule

>>> rtl/integer_pixel_scaler.sv
// integer pixel scaler, nearest neighbor, whole-number factor
// req_i takes requests: req_type 0 carries a new pixel, 1 asks for one replay
// step from the line buffer. res_o delivers output pixels with row_end and
// last (last marks the final result of a request).
// enlarge mode: a new pixel gives factor copies and is stored in the line
// buffer; after a full row, factor-1 replay passes of the row are pending and
// each replay request gives factor copies of the next stored pixel.
// shrink mode: a pixel passes once per complete factor x factor block, else dropped.
// registers sit on the apb port; a write restarts the frame position.
// a request passes the holding stage, the emitter's job register and then its
// output register; a request with f results sends f pixels through the output
// port, one pixel per cycle while the receiver is ready; requests without
// results never reach the output port.
// a request is taken while the previous one is still being emitted.
// reset: factor 1, width 1, count 1, enlarge mode, frame position zero;
// line buffer content is undefined until written, no clearing pass.
// when the receiver stalls the output register holds and requests back up
// through the emitter's job register and one holding stage, then req_i.ready drops.
`include "assert_macros.svh"

module integer_pixel_scaler import ips_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ips_req_if.sink           req_i,
  ips_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int FW  = $clog2(MAX_FACTOR + 1);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int SW  = ((WW > FW) ? WW : FW) + 2;
  localparam int RSW = ((ROW_W > FW) ? ROW_W : FW) + 2;

  // configuration registers
  logic                    mode_q;
  logic [FACTOR_REG_W-1:0] factor_q;
  logic [DIM_REG_W-1:0]    width_q;
  logic [DIM_REG_W-1:0]    count_q;

  // frame position and replay state
  logic [CW-1:0]        col_q, col_d;
  logic [ROW_IDX_W-1:0] row_q, row_d;
  logic [FW-1:0]        col_ph_q, col_ph_d;
  logic [FW-1:0]        row_ph_q, row_ph_d;
  logic [FW-1:0]        rp_pass_q, rp_pass_d;
  logic [CW-1:0]        rp_col_q, rp_col_d;

  // holding stage between accept and emitter
  logic             s1_valid_q;
  logic             s1_replay_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic             s1_ends_q;
  logic [FW-1:0]    s1_copies_q;

  // line buffer
  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rdata_q;

  logic          cfg_we;
  logic          acc;
  logic          job_take;
  ips_job_t      job;
  logic [FW-1:0] eff_f;
  logic [WW-1:0] eff_w;
  logic [ROW_W-1:0] eff_h;

  logic          produce;
  logic          prod_ends;
  logic [FW-1:0] prod_copies;
  logic          mem_we;
  logic          mem_re;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (ips_reg_e'(paddr[3:2]))
      REG_MODE:   prdata = APB_DW'(mode_q);
      REG_FACTOR: prdata = APB_DW'(factor_q);
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_COUNT:  prdata = APB_DW'(count_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_UP;
      factor_q <= FACTOR_REG_W'(1);
      width_q  <= DIM_REG_W'(1);
      count_q  <= DIM_REG_W'(1);
    end else if (cfg_we) begin
      case (ips_reg_e'(paddr[3:2]))
        REG_MODE:   mode_q   <= pwdata[0];
        REG_FACTOR: factor_q <= pwdata[FACTOR_REG_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[DIM_REG_W-1:0];
        REG_COUNT:  count_q  <= pwdata[DIM_REG_W-1:0];
        default:    mode_q   <= mode_q;
      endcase
    end
  end

  // effective factor and frame size after clamping
  always_comb begin
    if (factor_q == '0) begin
      eff_f = FW'(1);
    end else if (32'(factor_q) > MAX_FACTOR) begin
      eff_f = FW'(MAX_FACTOR);
    end else begin
      eff_f = FW'(factor_q);
    end
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (count_q == '0) begin
      eff_h = ROW_W'(1);
    end else if (32'(count_q) > MAX_ROWS) begin
      eff_h = ROW_W'(MAX_ROWS);
    end else begin
      eff_h = ROW_W'(count_q);
    end
  end

  assign req_i.ready = !s1_valid_q || job_take;
  assign acc         = req_i.valid && req_i.ready;

  always_comb begin
    logic          col_last;
    logic          row_last;
    logic          rp_last;
    logic [FW-1:0] col_ph_inc;
    logic [FW-1:0] row_ph_inc;
    logic          col_fit;
    logic          row_fit;
    logic          col_end_dn;
    logic          pass;

    col_last = (SW'(col_q) + SW'(1)) >= SW'(eff_w);
    row_last = (RSW'(row_q) + RSW'(1)) >= RSW'(eff_h);
    rp_last  = (SW'(rp_col_q) + SW'(1)) >= SW'(eff_w);
    col_ph_inc = ((col_ph_q + FW'(1)) == eff_f) ? '0 : col_ph_q + FW'(1);
    row_ph_inc = ((row_ph_q + FW'(1)) == eff_f) ? '0 : row_ph_q + FW'(1);
    // in pixel units: the block starting here fits inside the kept area
    col_fit    = (SW'(col_q) + SW'(eff_f)) <= SW'(eff_w);
    row_fit    = (RSW'(row_q) + RSW'(eff_f)) <= RSW'(eff_h);
    col_end_dn = col_fit && ((SW'(col_q) + SW'(eff_f) + SW'(eff_f)) > SW'(eff_w));
    pass       = (col_ph_q == '0) && (row_ph_q == '0) && col_fit && row_fit;

    col_d       = col_q;
    row_d       = row_q;
    col_ph_d    = col_ph_q;
    row_ph_d    = row_ph_q;
    rp_pass_d   = rp_pass_q;
    rp_col_d    = rp_col_q;
    produce     = 1'b0;
    prod_ends   = 1'b0;
    prod_copies = eff_f;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    if (cfg_we) begin
      col_d     = '0;
      row_d     = '0;
      col_ph_d  = '0;
      row_ph_d  = '0;
      rp_pass_d = '0;
      rp_col_d  = '0;
    end else if (acc) begin
      if (req_i.req_type == REQ_REPLAY) begin
        if (mode_q == MODE_UP && rp_pass_q != '0) begin
          produce   = 1'b1;
          prod_ends = rp_last;
          mem_re    = 1'b1;
          if (rp_last) begin
            rp_col_d  = '0;
            rp_pass_d = rp_pass_q - FW'(1);
          end else begin
            rp_col_d = rp_col_q + CW'(1);
          end
        end
      end else begin
        // new pixel: advance the input position
        if (col_last) begin
          col_d    = '0;
          col_ph_d = '0;
          if (row_last) begin
            row_d    = '0;
            row_ph_d = '0;
          end else begin
            row_d    = row_q + ROW_IDX_W'(1);
            row_ph_d = row_ph_inc;
          end
        end else begin
          col_d    = col_q + CW'(1);
          col_ph_d = col_ph_inc;
        end
        if (mode_q == MODE_UP) begin
          produce   = 1'b1;
          prod_ends = col_last;
          mem_we    = 1'b1;
          // a new pixel cancels pending replays
          rp_col_d  = '0;
          rp_pass_d = col_last ? (eff_f - FW'(1)) : '0;
        end else begin
          produce     = pass;
          prod_ends   = col_end_dn;
          prod_copies = FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      col_ph_q   <= '0;
      row_ph_q   <= '0;
      rp_pass_q  <= '0;
      rp_col_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      col_ph_q  <= col_ph_d;
      row_ph_q  <= row_ph_d;
      rp_pass_q <= rp_pass_d;
      rp_col_q  <= rp_col_d;
      if (acc) begin
        s1_valid_q <= produce;
      end else if (job_take) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_replay_q <= (req_i.req_type == REQ_REPLAY);
      s1_pix_q    <= req_i.pixel_in;
      s1_ends_q   <= prod_ends;
      s1_copies_q <= prod_copies;
    end
  end

  // line buffer: write of a new pixel, registered read for replay
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[col_q] <= req_i.pixel_in;
    end
    if (mem_re) begin
      rdata_q <= line_mem[rp_col_q];
    end
  end

  assign job.pixel   = s1_replay_q ? rdata_q : s1_pix_q;
  assign job.row_end = s1_ends_q;

  ips_emit #(
    .FW(FW)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(s1_valid_q),
    .job_i      (job),
    .copies_i   (s1_copies_q),
    .job_take_o (job_take),
    .res_o      (res_o)
  );

  `ASSERT_ALWAYS(a_pass_below_factor, clk_i, rst_ni, rp_pass_q < eff_f)
  `ASSERT_NEXT(a_cfg_restarts, clk_i, rst_ni, cfg_we, (col_q == '0) && (rp_pass_q == '0) && (row_q == '0))
  `ASSERT_IMPLIES(a_row_end_last, clk_i, rst_ni, res_o.valid && res_o.row_end, res_o.last)

endmodule

>>> tb/integer_pixel_scaler_tb.sv
module integer_pixel_scaler_tb;
  import ips_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W       = 4096;
  localparam int MAX_F       = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_ITEMS  = 200;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pix;
  } scaler_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             last;
  } scaled_pix_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ips_req_if req_if ();
  ips_res_if res_if ();

  integer_pixel_scaler dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  scaler_req_t req_q[$];
  scaled_pix_t expected_pix_q[$];
  int          errors = 0;
  int          cycle_cnt = 0;

  // predictor copy of registers and frame position
  logic             cfg_mode;
  logic [3:0]       cfg_factor;
  logic [12:0]      cfg_width;
  logic [12:0]      cfg_count;
  logic [PIX_W-1:0] line_mem [MAX_W];
  int               in_col;
  int               in_row;
  int               replay_left;
  int               replay_col;

  function automatic int eff_factor();
    int f;
    f = int'(cfg_factor);
    if (f == 0) f = 1;
    if (f > MAX_F) f = MAX_F;
    return f;
  endfunction

  function automatic int eff_width();
    int w;
    w = int'(cfg_width);
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int eff_rows();
    int h;
    h = int'(cfg_count);
    if (h == 0) h = 1;
    if (h > MAX_ROWS) h = MAX_ROWS;
    return h;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pix();
    return PIX_W'($urandom());
  endfunction

  task automatic restart_position();
    in_col      = 0;
    in_row      = 0;
    replay_left = 0;
    replay_col  = 0;
  endtask

  task automatic step_position(input int w, input int h);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (in_row >= h) in_row = 0;
    end
  endtask

  task automatic push_copies(input logic [PIX_W-1:0] pix, input int f, input logic ends);
    scaled_pix_t p;
    for (int k = 0; k < f; k++) begin
      p.pixel   = pix;
      p.last    = (k == f - 1);
      p.row_end = p.last && ends;
      expected_pix_q.push_back(p);
    end
  endtask

  // expected output pixels for one accepted request
  task automatic scale_request(input logic kind, input logic [PIX_W-1:0] pix);
    int   f;
    int   w;
    int   h;
    int   col;
    int   row;
    int   keep_w;
    int   keep_h;
    logic ends;
    logic pass;
    f = eff_factor();
    w = eff_width();
    h = eff_rows();
    if (cfg_mode == MODE_UP) begin
      if (kind == REQ_REPLAY) begin
        if (replay_left != 0) begin
          col  = replay_col;
          ends = (col + 1 >= w);
          replay_col++;
          if (replay_col >= w) begin
            replay_col = 0;
            replay_left--;
          end
          push_copies(line_mem[col], f, ends);
        end
      end else begin
        col         = in_col;
        ends        = (col + 1 >= w);
        replay_left = 0;
        replay_col  = 0;
        line_mem[col] = pix;
        step_position(w, h);
        if (ends) replay_left = f - 1;
        push_copies(pix, f, ends);
      end
    end else if (kind == REQ_PIXEL) begin
      keep_w = (w / f) * f;
      keep_h = (h / f) * f;
      col    = in_col;
      row    = in_row;
      pass   = (col < keep_w) && (row < keep_h) && (col % f == 0) && (row % f == 0);
      step_position(w, h);
      if (pass) push_copies(pix, 1, col + f == keep_w);
    end
  endtask

  task automatic write_reg(input ips_reg_e idx, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:   cfg_mode   = data[0];
      REG_FACTOR: cfg_factor = data[3:0];
      REG_WIDTH:  cfg_width  = data[12:0];
      REG_COUNT:  cfg_count  = data[12:0];
      default: ;
    endcase
    restart_position();
  endtask

  // upper bits carry noise, only the register field must count
  task automatic set_config(input logic mode, input logic [3:0] fac,
                            input logic [12:0] wid, input logic [12:0] cnt);
    logic [APB_DW-1:0] noise;
    noise = $urandom();
    write_reg(REG_MODE, {noise[APB_DW-1:1], mode});
    write_reg(REG_FACTOR, {noise[APB_DW-1:4], fac});
    write_reg(REG_WIDTH, {noise[APB_DW-1:13], wid});
    write_reg(REG_COUNT, {noise[APB_DW-1:13], cnt});
  endtask

  task automatic push_req(input logic kind, input logic [PIX_W-1:0] pix);
    scaler_req_t r;
    r.kind = kind;
    r.pix  = pix;
    req_q.push_back(r);
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || req_if.valid || expected_pix_q.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // request driver: bursts of random length, random gaps
  scaler_req_t next_req;
  int          burst_left = 1;
  int          gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.req_type <= REQ_PIXEL;
      req_if.pixel_in <= '0;
    end else begin
      if (req_if.valid && req_if.ready) scale_request(req_if.req_type, req_if.pixel_in);
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          next_req = req_q.pop_front();
          req_if.valid    <= 1'b1;
          req_if.req_type <= next_req.kind;
          req_if.pixel_in <= next_req.pix;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor, receiver stalls on its own pattern
  int          hold_left = 0;
  scaled_pix_t want_pix;
  scaled_pix_t got_pix;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (hold_left == 0) begin
        if (res_if.ready) begin
          res_if.ready <= 1'b0;
          hold_left    <= $urandom_range(1, 5);
        end else begin
          res_if.ready <= 1'b1;
          hold_left    <= ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        end
      end else begin
        hold_left <= hold_left - 1;
      end
      if (res_if.valid && res_if.ready) begin
        got_pix = {res_if.pixel_out, res_if.row_end, res_if.last};
        if (expected_pix_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected output pixel %h row_end %b last %b",
                     got_pix.pixel, got_pix.row_end, got_pix.last);
        end else begin
          want_pix = expected_pix_q.pop_front();
          if (got_pix !== want_pix) begin
            errors++;
            if (errors <= 10)
              $display("pixel mismatch: expected %h row_end %b last %b, got %h row_end %b last %b",
                       want_pix.pixel, want_pix.row_end, want_pix.last,
                       got_pix.pixel, got_pix.row_end, got_pix.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("integer_pixel_scaler_tb NOT OK");
      $finish;
    end
  end

  initial begin : main
    int          rand_items;
    int          n;
    int          n_rows;
    int          ef;
    int          ew;
    int          eh;
    logic        big;
    logic        mode;
    logic [3:0]  fac;
    logic [12:0] wid;
    logic [12:0] cnt;
    rand_items = 0;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_PIXEL;
    req_if.pixel_in = '0;
    res_if.ready    = 1'b0;
    cfg_mode   = MODE_UP;
    cfg_factor = 4'd1;
    cfg_width  = 13'd1;
    cfg_count  = 13'd1;
    restart_position();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, replay with none pending
    push_req(REQ_PIXEL, 24'hFFFFFF);
    push_req(REQ_REPLAY, 24'h000000);
    push_req(REQ_PIXEL, 24'h000000);
    wait_idle();

    // enlarge 3x on a 2x2 frame: replays, extra replay, cancel, frame wrap
    set_config(MODE_UP, 4'd3, 13'd2, 13'd2);
    push_req(REQ_PIXEL, 24'h123456);
    push_req(REQ_PIXEL, 24'hABCDEF);
    repeat (5) push_req(REQ_REPLAY, rand_pix());
    push_req(REQ_PIXEL, 24'h5A5A5A);
    push_req(REQ_PIXEL, 24'hA5A5A5);
    push_req(REQ_REPLAY, rand_pix());
    push_req(REQ_PIXEL, 24'h0F0F0F);
    wait_idle();

    // zero factor, width and count act as one
    set_config(MODE_UP, 4'd0, 13'd0, 13'd0);
    push_req(REQ_PIXEL, rand_pix());
    push_req(REQ_REPLAY, rand_pix());
    wait_idle();

    // factor beyond the maximum saturates
    set_config(MODE_UP, 4'd15, 13'd3, 13'd1);
    repeat (3) push_req(REQ_PIXEL, rand_pix());
    push_req(REQ_REPLAY, rand_pix());
    wait_idle();

    // shrink 2x on 3x2, leftover column dropped, replay ignored
    set_config(MODE_DOWN, 4'd2, 13'd3, 13'd2);
    push_req(REQ_REPLAY, rand_pix());
    repeat (6) push_req(REQ_PIXEL, rand_pix());
    wait_idle();

    while (rand_items < RAND_ITEMS) begin
      mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       fac = 4'd0;
        1:       fac = 4'd15;
        2:       fac = 4'd8;
        3:       fac = 4'($urandom());
        default: fac = 4'($urandom_range(1, 8));
      endcase
      big = ($urandom_range(0, 7) == 0);
      if (big) begin
        case ($urandom_range(0, 2))
          0:       wid = 13'd4096;
          1:       wid = 13'd8191;
          default: wid = 13'($urandom());
        endcase
        case ($urandom_range(0, 2))
          0:       cnt = 13'd8191;
          1:       cnt = 13'd0;
          default: cnt = 13'($urandom());
        endcase
      end else begin
        wid = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 5));
        cnt = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 4));
      end
      set_config(mode, fac, wid, cnt);
      ef = eff_factor();
      ew = eff_width();
      eh = eff_rows();
      if (big || ew > 16) begin
        n = $urandom_range(5, 20);
        for (int i = 0; i < n; i++) push_req(1'($urandom_range(0, 1)), rand_pix());
      end else if (mode == MODE_UP) begin
        n_rows = $urandom_range(1, 3);
        for (int r = 0; r < n_rows; r++) begin
          for (int c = 0; c < ew; c++) push_req(REQ_PIXEL, rand_pix());
          for (int k = 0; k < (ef - 1) * ew; k++) begin
            // a new pixel here cuts the pending replays short
            if ($urandom_range(0, 29) == 0) push_req(REQ_PIXEL, rand_pix());
            push_req(REQ_REPLAY, rand_pix());
          end
          if ($urandom_range(0, 3) == 0) push_req(REQ_REPLAY, rand_pix());
        end
      end else begin
        n = ew * eh * $urandom_range(1, 2);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 9) == 0) push_req(REQ_REPLAY, rand_pix());
          push_req(REQ_PIXEL, rand_pix());
        end
      end
      rand_items += req_q.size();
      wait_idle();
    end

    repeat (20) @(negedge clk_i);
    if (errors == 0 && expected_pix_q.size() == 0) begin
      $display("integer_pixel_scaler_tb OK");
    end else begin
      $display("integer_pixel_scaler_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> integer_pixel_scaler.f
+incdir+rtl
rtl/ips_pkg.sv
rtl/ips_req_if.sv
rtl/ips_res_if.sv
rtl/ips_emit.sv
rtl/integer_pixel_scaler.sv
tb/integer_pixel_scaler_tb.sv
